FILE: hw/rtl/trg_pkg.sv
// Shared types and constants for the trapezoidal reference generator.
package trg_pkg;

  localparam int PosW = 32;
  localparam int MvW  = 31;
  localparam int AtW  = 32;
  localparam int TsW  = 16;
  localparam int DvdW = 64;
  localparam int DvsW = 33;

  localparam logic [1:0] PH_STOP   = 2'd0;
  localparam logic [1:0] PH_ACCEL  = 2'd1;
  localparam logic [1:0] PH_CRUISE = 2'd2;
  localparam logic [1:0] PH_DECEL  = 2'd3;

  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_SET    = 4'd1;
  localparam logic [3:0] OP_DIVA   = 4'd2;
  localparam logic [3:0] OP_DV     = 4'd3;
  localparam logic [3:0] OP_VEL    = 4'd4;
  localparam logic [3:0] OP_PMUL   = 4'd5;
  localparam logic [3:0] OP_POS    = 4'd6;
  localparam logic [3:0] OP_DIVB   = 4'd7;
  localparam logic [3:0] OP_DECIDE = 4'd8;

  localparam logic [1:0] REG_MV = 2'd0;
  localparam logic [1:0] REG_AT = 2'd1;
  localparam logic [1:0] REG_TS = 2'd2;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } status_t;

endpackage

FILE: hw/rtl/trg_div.sv
// Restoring divider, one quotient bit per cycle.
module trg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [trg_pkg::DvdW-1:0]  dividend,
  input  logic [trg_pkg::DvsW-1:0]  divisor,
  output logic                      busy,
  output logic [trg_pkg::DvdW-1:0]  quotient
);

  logic [trg_pkg::DvdW-1:0] q_r, q_nxt;
  logic [trg_pkg::DvsW-1:0] dvs_r;
  logic [trg_pkg::DvsW:0]   rem_r, rem_nxt, shifted;
  logic [6:0]               cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;

  always_comb begin
    shifted  = {rem_r[trg_pkg::DvsW-1:0], q_r[trg_pkg::DvdW-1]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 7'(trg_pkg::DvdW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
        q_nxt   = {q_r[trg_pkg::DvdW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt   = {q_r[trg_pkg::DvdW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/trg_datapath.sv
// Datapath: motion state, step arithmetic and braking decision.
module trg_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  trg_pkg::cmd_t                   cmd,
  output trg_pkg::status_t                status,
  input  logic signed [trg_pkg::PosW-1:0] in_target,
  input  logic [trg_pkg::MvW-1:0]         max_velocity,
  input  logic [trg_pkg::AtW-1:0]         acceleration_time,
  input  logic [trg_pkg::TsW-1:0]         sample_time,
  output logic signed [trg_pkg::PosW-1:0] position,
  output logic [1:0]                      phase
);

  logic [1:0]                      phase_r, phase_nxt;
  logic                            dir_neg_r, dir_neg_nxt;
  logic signed [trg_pkg::PosW-1:0] target_r, target_nxt;
  logic signed [trg_pkg::PosW-1:0] pos_r, pos_nxt;
  logic signed [trg_pkg::PosW-1:0] vel_r, vel_nxt;
  logic [30:0]                     a_r, a_nxt, dv_r, dv_nxt, pm_r, pm_nxt;

  logic                      div_start, div_busy;
  logic [trg_pkg::DvdW-1:0]  div_dvd, div_q;
  logic [trg_pkg::DvsW-1:0]  div_dvs;
  logic [31:0]               vmag;
  logic [46:0]               dv_prod;
  logic [47:0]               pm_prod;
  logic [30:0]               a_sat;
  logic signed [65:0]        brake_dist, pos_w, tgt_w;
  logic                      brake, stopped;
  logic signed [32:0]        miss;
  logic [32:0]               miss_abs;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    logic signed [31:0] r;
    if (x > 34'sh07FFFFFFF)       r = 32'sh7FFFFFFF;
    else if (x < -34'sh080000000) r = 32'sh80000000;
    else                          r = x[31:0];
    return r;
  endfunction

  assign vmag     = vel_r[31] ? 32'(-vel_r) : 32'(vel_r);
  assign div_start = (cmd.op == trg_pkg::OP_DIVA) || (cmd.op == trg_pkg::OP_DIVB);

  always_comb begin
    if (cmd.op == trg_pkg::OP_DIVA) begin
      div_dvd = {17'd0, max_velocity, 16'd0};
      div_dvs = {1'b0, acceleration_time};
    end else begin
      div_dvd = 64'(vmag) * 64'(vmag);
      div_dvs = {1'b0, a_r, 1'b0};
    end
  end

  trg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    a_sat      = (|div_q[63:31]) ? 31'h7FFFFFFF : div_q[30:0];
    dv_prod    = 47'(a_sat) * 47'(sample_time);
    pm_prod    = 48'(vmag) * 48'(sample_time);
    brake_dist = (a_r == '0) ? (66'sd1 <<< 62) : $signed({2'b00, div_q});
    pos_w      = 66'(pos_r);
    tgt_w      = 66'(target_r);
    brake      = dir_neg_r ? (pos_w <= tgt_w + brake_dist) : (pos_w >= tgt_w - brake_dist);
    stopped    = dir_neg_r ? !vel_r[31] : (vel_r[31] || vel_r == '0);
    miss       = 33'(pos_r) - 33'(target_r);
    miss_abs   = miss[32] ? 33'(-miss) : 33'(miss);
  end

  always_comb begin
    phase_nxt   = phase_r;
    dir_neg_nxt = dir_neg_r;
    target_nxt  = target_r;
    pos_nxt     = pos_r;
    vel_nxt     = vel_r;
    a_nxt       = a_r;
    dv_nxt      = dv_r;
    pm_nxt      = pm_r;
    unique case (cmd.op)
      trg_pkg::OP_SET: begin
        target_nxt  = in_target;
        phase_nxt   = trg_pkg::PH_ACCEL;
        dir_neg_nxt = !(in_target > pos_r);
      end
      trg_pkg::OP_DV: begin
        a_nxt  = a_sat;
        dv_nxt = dv_prod[46:16];
      end
      trg_pkg::OP_VEL: begin
        unique case (phase_r)
          trg_pkg::PH_ACCEL:
            vel_nxt = dir_neg_r ? sat32(34'(vel_r) - 34'(dv_r))
                                : sat32(34'(vel_r) + 34'(dv_r));
          trg_pkg::PH_CRUISE:
            vel_nxt = dir_neg_r ? -32'(max_velocity) : 32'(max_velocity);
          trg_pkg::PH_DECEL:
            vel_nxt = dir_neg_r ? sat32(34'(vel_r) + 34'(dv_r))
                                : sat32(34'(vel_r) - 34'(dv_r));
          default: vel_nxt = '0;
        endcase
      end
      trg_pkg::OP_PMUL: pm_nxt = pm_prod[46:16];
      trg_pkg::OP_POS: begin
        if (phase_r != trg_pkg::PH_STOP)
          pos_nxt = vel_r[31] ? sat32(34'(pos_r) - 34'(pm_r))
                              : sat32(34'(pos_r) + 34'(pm_r));
      end
      trg_pkg::OP_DECIDE: begin
        unique case (phase_r)
          trg_pkg::PH_ACCEL: begin
            if ({1'b0, vmag} > 33'(max_velocity)) phase_nxt = trg_pkg::PH_CRUISE;
            if (brake) phase_nxt = trg_pkg::PH_DECEL;
          end
          trg_pkg::PH_CRUISE: begin
            if (brake) phase_nxt = trg_pkg::PH_DECEL;
          end
          trg_pkg::PH_DECEL: begin
            if (stopped) begin
              if (miss_abs > 33'(10 * 65536)) begin
                phase_nxt   = trg_pkg::PH_ACCEL;
                dir_neg_nxt = !(target_r > pos_r);
              end else begin
                phase_nxt = trg_pkg::PH_STOP;
                pos_nxt   = target_r;
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= trg_pkg::PH_STOP;
      dir_neg_r <= 1'b0;
      target_r  <= '0;
      pos_r     <= '0;
      vel_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      dir_neg_r <= dir_neg_nxt;
      target_r  <= target_nxt;
      pos_r     <= pos_nxt;
      vel_r     <= vel_nxt;
    end
    a_r  <= a_nxt;
    dv_r <= dv_nxt;
    pm_r <= pm_nxt;
  end

  assign status.div_busy = div_busy;
  assign position        = pos_r;
  assign phase           = phase_r;

endmodule

FILE: hw/rtl/trg_ctrl.sv
// Controller: sequences one request through the datapath.
module trg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_opcode,
  output logic              in_stall,
  input  logic              out_busy,
  output logic              out_load,
  output trg_pkg::cmd_t     cmd,
  input  trg_pkg::status_t  status
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WAITA  = 4'd1;
  localparam logic [3:0] S_DV     = 4'd2;
  localparam logic [3:0] S_VEL    = 4'd3;
  localparam logic [3:0] S_PMUL   = 4'd4;
  localparam logic [3:0] S_POS    = 4'd5;
  localparam logic [3:0] S_DIVB   = 4'd6;
  localparam logic [3:0] S_WAITB  = 4'd7;
  localparam logic [3:0] S_DECIDE = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = trg_pkg::OP_NONE;
    out_load  = 1'b0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode) begin
            cmd.op    = trg_pkg::OP_SET;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = trg_pkg::OP_DIVA;
            state_nxt = S_WAITA;
          end
        end
      end
      S_WAITA:  if (!status.div_busy) state_nxt = S_DV;
      S_DV: begin
        cmd.op    = trg_pkg::OP_DV;
        state_nxt = S_VEL;
      end
      S_VEL: begin
        cmd.op    = trg_pkg::OP_VEL;
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        cmd.op    = trg_pkg::OP_PMUL;
        state_nxt = S_POS;
      end
      S_POS: begin
        cmd.op    = trg_pkg::OP_POS;
        state_nxt = S_DIVB;
      end
      S_DIVB: begin
        cmd.op    = trg_pkg::OP_DIVB;
        state_nxt = S_WAITB;
      end
      S_WAITB:  if (!status.div_busy) state_nxt = S_DECIDE;
      S_DECIDE: begin
        cmd.op    = trg_pkg::OP_DECIDE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

FILE: hw/rtl/trapezoidal_reference_generator.sv
// Top level: configuration registers, result register, controller and datapath.
// Trapezoidal position reference generator. A set request (opcode 1) loads a new
// target; a tick request (opcode 0) takes two passes of the shared 64-bit
// divider (one quotient bit per cycle), one for acceleration from the
// configuration registers and one for the braking distance. One request is
// worked at a time; a new request is taken while the previous result still
// waits in the output register. Every request yields one result with the
// reference position and phase.
module trapezoidal_reference_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_opcode,
  input  logic signed [31:0]  in_target,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_reference,
  output logic [1:0]          out_phase,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [trg_pkg::MvW-1:0]  mv_r;
  logic [trg_pkg::AtW-1:0]  at_r;
  logic [trg_pkg::TsW-1:0]  ts_r;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [31:0]       out_ref_r;
  logic [1:0]               out_phase_r;
  logic                     out_load, wr;
  trg_pkg::cmd_t            cmd;
  trg_pkg::status_t         status;
  logic signed [31:0]       position;
  logic [1:0]               phase;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 31'd65536;
      at_r <= 32'd65536;
      ts_r <= 16'd655;
    end else if (wr) begin
      unique case (paddr[3:2])
        trg_pkg::REG_MV: mv_r <= pwdata[30:0];
        trg_pkg::REG_AT: at_r <= pwdata;
        trg_pkg::REG_TS: ts_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      trg_pkg::REG_MV: prdata = {1'b0, mv_r};
      trg_pkg::REG_AT: prdata = at_r;
      trg_pkg::REG_TS: prdata = {16'd0, ts_r};
      default:         prdata = '0;
    endcase
  end

  trg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_busy  (out_valid_r && out_stall),
    .out_load  (out_load),
    .cmd       (cmd),
    .status    (status)
  );

  trg_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_target         (in_target),
    .max_velocity      (mv_r),
    .acceleration_time (at_r),
    .sample_time       (ts_r),
    .position          (position),
    .phase             (phase)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    if (out_load) begin
      out_ref_r   <= position;
      out_phase_r <= phase;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_reference = out_ref_r;
  assign out_phase     = out_phase_r;

endmodule

FILE: tb/sv/trapezoidal_reference_generator_test.sv
// Testbench for the trapezoidal reference generator: directed and random stimulus, predicted results.
module trapezoidal_reference_generator_test;

  typedef struct packed {
    logic        opcode;
    logic [31:0] target;
  } request_t;

  typedef struct packed {
    logic [31:0] reference;
    logic [1:0]  phase;
  } position_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic signed [31:0] in_target = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_reference;
  logic [1:0] out_phase;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  trapezoidal_reference_generator i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_target,
    .out_valid, .out_stall, .out_reference, .out_phase,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk = ~clk;

  request_t  pending_requests[$];
  position_t expected_positions[$];
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_cycles = 0;
  bit stimulus_done = 1'b0;
  bit long_hold_done = 1'b0;
  bit in_taken = 1'b0;

  // predictor state
  longint mv_q, at_q, ts_q;
  logic [1:0] ph_q;
  bit neg_q;
  longint tgt_q, pos_q, vel_q;

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint scale_q16(longint x, longint y);
    longint unsigned m, p;
    m = (x < 0) ? -x : x;
    p = (m * y) >> 16;
    return (x < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic bit past_brake_point(longint a);
    longint unsigned m;
    longint d;
    m = (vel_q < 0) ? -vel_q : vel_q;
    d = (a <= 0) ? (64'sd1 <<< 62) : longint'((m * m) / (longint'(a) * 2));
    if (neg_q) return pos_q <= tgt_q + d;
    return pos_q >= tgt_q - d;
  endfunction

  function automatic position_t predict_position(request_t r);
    longint unsigned q;
    longint a, dv, absv, miss;
    position_t res;
    if (at_q == 0) a = 64'sd2147483647;
    else begin
      q = (longint'(mv_q) << 16) / at_q;
      a = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    end
    dv = scale_q16(a, ts_q);
    if (r.opcode) begin
      tgt_q = longint'(signed'(r.target));
      ph_q = trg_pkg::PH_ACCEL;
      neg_q = !(tgt_q > pos_q);
    end else begin
      case (ph_q)
        trg_pkg::PH_ACCEL: begin
          vel_q = sat32(neg_q ? vel_q - dv : vel_q + dv);
          pos_q = sat32(pos_q + scale_q16(vel_q, ts_q));
          absv = (vel_q < 0) ? -vel_q : vel_q;
          if (absv > mv_q) ph_q = trg_pkg::PH_CRUISE;
          if (past_brake_point(a)) ph_q = trg_pkg::PH_DECEL;
        end
        trg_pkg::PH_CRUISE: begin
          vel_q = neg_q ? -mv_q : mv_q;
          pos_q = sat32(pos_q + scale_q16(vel_q, ts_q));
          if (past_brake_point(a)) ph_q = trg_pkg::PH_DECEL;
        end
        trg_pkg::PH_DECEL: begin
          vel_q = sat32(neg_q ? vel_q + dv : vel_q - dv);
          pos_q = sat32(pos_q + scale_q16(vel_q, ts_q));
          if (neg_q ? vel_q >= 0 : vel_q <= 0) begin
            ph_q = trg_pkg::PH_STOP;
            miss = pos_q - tgt_q;
            if (miss < 0) miss = -miss;
            if (miss > 64'sd655360) begin
              ph_q = trg_pkg::PH_ACCEL;
              neg_q = !(tgt_q > pos_q);
            end else pos_q = tgt_q;
          end
        end
        default: vel_q = 0;
      endcase
    end
    res.reference = pos_q[31:0];
    res.phase = ph_q;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // request acceptance and prediction
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) expected_positions.push_back(
        predict_position(request_t'({in_opcode, in_target})));
  end

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
      if (gap_left > 0 || pending_requests.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end else begin
        request_t r;
        r = pending_requests.pop_front();
        burst_left--;
        in_valid <= 1'b1;
        in_opcode <= r.opcode;
        in_target <= r.target;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (pending_requests.size() == 100 && in_valid && !stimulus_done &&
                 !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_cycles = 3000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_positions.size() == 0) begin
        report_mismatch("unexpected result", out_reference, 0);
      end else begin
        position_t e;
        e = expected_positions.pop_front();
        if (out_reference !== e.reference)
          report_mismatch("reference", out_reference, e.reference);
        if (out_phase !== e.phase) report_mismatch("phase", out_phase, e.phase);
      end
    end
  end

  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      trg_pkg::REG_MV: mv_q = value[30:0];
      trg_pkg::REG_AT: at_q = value;
      default: ts_q = value[15:0];
    endcase
  endtask

  task automatic queue_request(logic opcode, logic [31:0] target);
    pending_requests.push_back({opcode, target});
  endtask

  task automatic drain_results();
    while (pending_requests.size() != 0 || in_valid || expected_positions.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic queue_move(int ticks);
    logic [31:0] t;
    t = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 32'h003f_ffff);
    if ($urandom_range(0, 1)) t = -t;
    queue_request(1'b1, t);
    for (int k = 0; k < ticks; k++) queue_request(1'b0, $urandom);
  endtask

  initial begin
    mv_q = 65536; at_q = 65536; ts_q = 655;
    ph_q = trg_pkg::PH_STOP; neg_q = 0; tgt_q = 0; pos_q = 0; vel_q = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed
    queue_request(1'b0, 32'h0);
    queue_request(1'b1, 32'h7fff_ffff);
    repeat (4) queue_request(1'b0, 32'hffff_ffff);
    queue_request(1'b1, 32'h8000_0000);
    repeat (4) queue_request(1'b0, 32'h0);
    queue_request(1'b1, 32'h0000_0000);
    repeat (6) queue_request(1'b0, 32'h0);
    drain_results();
    write_register(trg_pkg::REG_MV, 32'h7fff_ffff);
    write_register(trg_pkg::REG_AT, 32'h0000_0001);
    write_register(trg_pkg::REG_TS, 32'h0000_ffff);
    queue_move(8); queue_move(6);
    drain_results();
    write_register(trg_pkg::REG_MV, 32'h0000_0001);
    write_register(trg_pkg::REG_AT, 32'hffff_ffff);
    write_register(trg_pkg::REG_TS, 32'h0000_0000);
    queue_move(5);
    drain_results();
    write_register(trg_pkg::REG_TS, 32'h0000_0001);
    queue_move(5);
    drain_results();
    // random phases, mostly mild settings so moves complete
    for (int p = 0; p < 6; p++) begin
      write_register(trg_pkg::REG_MV,
                     (p == 5) ? $urandom : $urandom_range(32'h1000, 32'h80000));
      write_register(trg_pkg::REG_AT,
                     (p == 4) ? $urandom : $urandom_range(32'h4000, 32'h40000));
      write_register(trg_pkg::REG_TS, (p == 3) ? $urandom : $urandom_range(600, 8000));
      while (pending_requests.size() < 50) queue_move($urandom_range(3, 30));
      if (p == 2) for (int k = 0; k < 100; k++) queue_request(1'b0, $urandom);
      drain_results();
    end
    stimulus_done = 1'b1;
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
